// ===== sv/rnts_pkg.sv =====
// ----------------------------------------------------------------------------
// rnts_pkg: shared types and constants for the radix number-to-symbols unit
// Command and result word layouts, action codes, and sizing constants.
// ----------------------------------------------------------------------------
package rnts_pkg;

	localparam int MAX_SYMBOLS = 64;
	localparam int NUMBER_BITS = 32;

	// symbol count holds 0..MAX_SYMBOLS
	localparam int CNT_W  = $clog2(MAX_SYMBOLS + 1);
	// one digit value, also the alphabet address
	localparam int DIG_W  = $clog2(MAX_SYMBOLS);
	// digit stack depth holds 0..NUMBER_BITS
	localparam int DEP_W  = $clog2(NUMBER_BITS + 1);
	localparam int STK_AW = $clog2(NUMBER_BITS);
	localparam int BIT_W  = $clog2(NUMBER_BITS);

	localparam logic [1:0] ACT_CLEAR   = 2'd0;
	localparam logic [1:0] ACT_APPEND  = 2'd1;
	localparam logic [1:0] ACT_CONVERT = 2'd2;

	localparam logic [7:0] SYM_MINUS = 8'h2D;
	localparam logic [7:0] SYM_PLUS  = 8'h2B;

	typedef struct packed {
		logic [1:0]                    action;
		logic [7:0]                    symbol;
		logic signed [NUMBER_BITS-1:0] number;
	} rnts_cmd_t;

	typedef struct packed {
		logic [7:0] out_symbol;
		logic       last;
	} rnts_res_t;

endpackage

// ===== sv/radix_number_to_symbols_unit.sv =====
// ----------------------------------------------------------------------------
// radix_number_to_symbols_unit: signed integer to text in a custom radix
// Builds a digit alphabet one symbol at a time and converts signed numbers
// into a stream of symbols, most significant digit first.
// ----------------------------------------------------------------------------
//
//  channel  | handshake             | word
//  ---------+-----------------------+---------------------------------------
//  command  | start / busy          | cmd    (action, symbol, number)
//  result   | result_valid (strobe) | result (out_symbol, last)
//
//  Clear and append complete without raising busy.
//  Convert: one restoring divider makes one quotient bit per cycle over all
//  NUMBER_BITS dividend bits for each digit, then each digit is looked up in
//  the alphabet RAM (S_RD, then S_OUT); zero skips the divider.
//  Reset clears count, seen map and bad flag; the alphabet RAM is not cleared.
//  Results are strobed for one cycle each; the receiver cannot stall them.
// ----------------------------------------------------------------------------
module radix_number_to_symbols_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  rnts_pkg::rnts_cmd_t cmd,
	output logic               result_valid,
	output rnts_pkg::rnts_res_t result
);

	import rnts_pkg::*;

	typedef enum logic [1:0] {S_IDLE, S_DIV, S_RD, S_OUT} state_t;

	state_t                 state_q;
	logic [CNT_W-1:0]       count_q;
	logic [255:0]           seen_q;
	logic                   bad_q;
	logic [DEP_W-1:0]       depth_q;
	logic [BIT_W-1:0]       bit_q;
	logic [CNT_W-1:0]       rem_q;
	logic [NUMBER_BITS-1:0] quo_q;
	logic                   res_valid_q;
	rnts_res_t              res_q;
	logic [DIG_W-1:0]       stack_q [NUMBER_BITS];

	logic                   accept;
	logic                   alpha_ok;
	logic [NUMBER_BITS-1:0] num_u;
	logic                   neg;
	logic [NUMBER_BITS-1:0] mag;
	logic [CNT_W:0]         rem_sh;
	logic [CNT_W:0]         rem_diff;
	logic                   ge;
	logic [CNT_W-1:0]       rem_nx;
	logic [NUMBER_BITS-1:0] quo_nx;
	logic                   last_bit;
	logic [DEP_W-1:0]       depth_m1;
	logic                   stk_we;
	logic [STK_AW-1:0]      stk_waddr;
	logic [DIG_W-1:0]       stk_wdata;
	logic                   ram_we;
	logic [DIG_W-1:0]       ram_raddr;
	logic [7:0]             ram_rdata;

	assign busy     = (state_q != S_IDLE);
	assign accept   = start && !busy;
	assign alpha_ok = !bad_q && (count_q >= CNT_W'(2));

	assign num_u = cmd.number;
	assign neg   = num_u[NUMBER_BITS-1];
	assign mag   = neg ? (~num_u + 1'b1) : num_u;

	// one restoring-division step: bring in the next dividend bit
	assign rem_sh   = {rem_q, quo_q[NUMBER_BITS-1]};
	assign rem_diff = rem_sh - {1'b0, count_q};
	assign ge       = (rem_sh >= {1'b0, count_q});
	assign rem_nx   = ge ? rem_diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
	assign quo_nx   = {quo_q[NUMBER_BITS-2:0], ge};
	assign last_bit = (bit_q == BIT_W'(NUMBER_BITS - 1));

	assign depth_m1 = depth_q - 1'b1;

	always_comb begin
		stk_we    = 1'b0;
		stk_waddr = depth_q[STK_AW-1:0];
		stk_wdata = rem_nx[DIG_W-1:0];
		if (state_q == S_IDLE) begin
			// zero converts to a single digit of value zero
			stk_we    = accept && (cmd.action == ACT_CONVERT) && alpha_ok && (mag == '0);
			stk_waddr = '0;
			stk_wdata = '0;
		end else if (state_q == S_DIV) begin
			stk_we = last_bit;
		end
	end

	assign ram_we = accept && (cmd.action == ACT_APPEND) && (cmd.symbol != 8'd0)
		&& (count_q < CNT_W'(MAX_SYMBOLS));
	assign ram_raddr = stack_q[depth_m1[STK_AW-1:0]];

	rnts_ram #(
		.WIDTH(8),
		.DEPTH(MAX_SYMBOLS)
	) u_alphabet (
		.clk  (clk),
		.we   (ram_we),
		.waddr(count_q[DIG_W-1:0]),
		.wdata(cmd.symbol),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (stk_we) begin
			stack_q[stk_waddr] <= stk_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			seen_q      <= '0;
			bad_q       <= 1'b0;
			depth_q     <= '0;
			bit_q       <= '0;
			rem_q       <= '0;
			quo_q       <= '0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			res_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (cmd.action)
							ACT_CLEAR: begin
								count_q <= '0;
								seen_q  <= '0;
								bad_q   <= 1'b0;
							end
							ACT_APPEND: begin
								if (cmd.symbol != 8'd0) begin
									if (count_q >= CNT_W'(MAX_SYMBOLS)) begin
										bad_q <= 1'b1;
									end else begin
										if (seen_q[cmd.symbol] || (cmd.symbol == SYM_MINUS)
											|| (cmd.symbol == SYM_PLUS)) begin
											bad_q <= 1'b1;
										end
										seen_q[cmd.symbol] <= 1'b1;
										count_q            <= count_q + 1'b1;
									end
								end
							end
							ACT_CONVERT: begin
								if (alpha_ok) begin
									if (neg) begin
										res_valid_q      <= 1'b1;
										res_q.out_symbol <= SYM_MINUS;
										res_q.last       <= 1'b0;
									end
									quo_q <= mag;
									rem_q <= '0;
									bit_q <= '0;
									if (mag == '0) begin
										depth_q <= DEP_W'(1);
										state_q <= S_RD;
									end else begin
										depth_q <= '0;
										state_q <= S_DIV;
									end
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_DIV: begin
					quo_q <= quo_nx;
					if (last_bit) begin
						// push the remainder digit, restart on the quotient
						rem_q   <= '0;
						bit_q   <= '0;
						depth_q <= depth_q + 1'b1;
						if ((quo_nx == '0) || (depth_q == DEP_W'(NUMBER_BITS - 1))) begin
							state_q <= S_RD;
						end
					end else begin
						rem_q <= rem_nx;
						bit_q <= bit_q + 1'b1;
					end
				end
				S_RD: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					res_valid_q      <= 1'b1;
					res_q.out_symbol <= ram_rdata;
					res_q.last       <= (depth_q == DEP_W'(1));
					depth_q          <= depth_m1;
					state_q          <= (depth_q == DEP_W'(1)) ? S_IDLE : S_RD;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= DEP_W'(NUMBER_BITS))
		else $error("digit stack depth out of range");

	a_rem_below_radix: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (rem_q < count_q))
		else $error("divider remainder not below radix");

	a_busy_valid_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> (!bad_q && (count_q >= CNT_W'(2))))
		else $error("conversion running on an invalid alphabet");

	a_last_ends_item: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.last) |-> !busy)
		else $error("final symbol emitted while still busy");

	a_emit_has_digits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RD || state_q == S_OUT) |-> (depth_q != '0))
		else $error("emission with an empty digit stack");

endmodule

// ===== sv/rnts_ram.sv =====
// ----------------------------------------------------------------------------
// rnts_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module rnts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule
